// ----- sv/clal_pkg.sv -----
`timescale 1ns / 1ps

package clal_pkg;

   // Flag bit positions within the 4-bit flag nibble.
   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   // Main opcodes handled outside the ALU groups.
   localparam logic [7:0] OPC_CPL = 8'h2F;
   localparam logic [7:0] OPC_SCF = 8'h37;
   localparam logic [7:0] OPC_CCF = 8'h3F;

   // Operand select codes that name the (HL) memory byte and the accumulator.
   localparam logic [2:0] TGT_HL = 3'd6;
   localparam logic [2:0] TGT_A  = 3'd7;

   // Logic group selected by opcode bits 4:3.
   localparam logic [1:0] GRP_AND = 2'd0;
   localparam logic [1:0] GRP_XOR = 2'd1;
   localparam logic [1:0] GRP_OR  = 2'd2;
   localparam logic [1:0] GRP_CP  = 2'd3;

   // Prefixed operation kind, opcode bits 7:6.
   localparam logic [1:0] KIND_SHIFT = 2'd0;
   localparam logic [1:0] KIND_BIT   = 2'd1;
   localparam logic [1:0] KIND_RES   = 2'd2;
   localparam logic [1:0] KIND_SET   = 2'd3;

   // Shift and rotate selector, opcode bits 5:3, when the kind is a shift.
   localparam logic [2:0] SHF_RLC  = 3'd0;
   localparam logic [2:0] SHF_RRC  = 3'd1;
   localparam logic [2:0] SHF_RL   = 3'd2;
   localparam logic [2:0] SHF_RR   = 3'd3;
   localparam logic [2:0] SHF_SLA  = 3'd4;
   localparam logic [2:0] SHF_SRA  = 3'd5;
   localparam logic [2:0] SHF_SWAP = 3'd6;
   localparam logic [2:0] SHF_SRL  = 3'd7;

   // Cycle counts charged per instruction form.
   localparam logic [4:0] CYC_REG     = 5'd4;
   localparam logic [4:0] CYC_MEM     = 5'd8;
   localparam logic [4:0] CYC_CB_REG  = 5'd12;
   localparam logic [4:0] CYC_CB_MEM  = 5'd20;

   typedef struct packed {
      logic       op;
      logic [7:0] opcode;
      logic [7:0] operand;
      logic [7:0] acc_in;
      logic [3:0] flags_in;
   } clal_item_type;

   typedef struct packed {
      logic [7:0] acc_out;
      logic [7:0] operand_out;
      logic       write_back;
      logic [3:0] flags_out;
      logic [4:0] cycles;
      logic       illegal;
   } clal_result_type;

endpackage

// ----- sv/clal_exec.sv -----
`timescale 1ns / 1ps

module clal_exec (
   input  clal_pkg::clal_item_type   item,
   output clal_pkg::clal_result_type result
);
   import clal_pkg::*;

   logic [7:0] a;
   logic [7:0] b;
   logic [3:0] f;
   logic [7:0] logic_res;
   logic [1:0] grp;
   logic       grp_hit;
   logic [7:0] mask;
   logic [7:0] cb_res;
   logic       cb_carry;
   logic [3:0] cb_flags;
   logic       cb_wb;

   assign a = item.acc_in;
   assign b = item.operand;
   assign f = item.flags_in;
   assign mask = 8'b1 << item.opcode[5:3];
   assign grp = item.opcode[4:3];

   // The register/(HL) forms live at A0-BF; the immediate forms are E6, EE, F6, FE.
   always_comb begin
      grp_hit = (item.opcode[7:5] == 3'b101) ||
                (item.opcode[7:5] == 3'b111 && item.opcode[2:0] == TGT_HL);
   end

   always_comb begin
      case (grp)
         GRP_AND: logic_res = a & b;
         GRP_XOR: logic_res = a ^ b;
         GRP_OR:  logic_res = a | b;
         default: logic_res = a;
      endcase
   end

   // Prefixed operations on the operand byte.
   always_comb begin
      cb_res   = b;
      cb_carry = 1'b0;
      cb_wb    = 1'b1;
      cb_flags = f;
      unique case (item.opcode[7:6])
         KIND_SHIFT: begin
            unique case (item.opcode[5:3])
               SHF_RLC:  begin cb_carry = b[7]; cb_res = {b[6:0], b[7]}; end
               SHF_RRC:  begin cb_carry = b[0]; cb_res = {b[0], b[7:1]}; end
               SHF_RL:   begin cb_carry = b[7]; cb_res = {b[6:0], f[FLAG_C]}; end
               SHF_RR:   begin cb_carry = b[0]; cb_res = {f[FLAG_C], b[7:1]}; end
               SHF_SLA:  begin cb_carry = b[7]; cb_res = {b[6:0], 1'b0}; end
               SHF_SRA:  begin cb_carry = b[0]; cb_res = {b[7], b[7:1]}; end
               SHF_SWAP: begin cb_carry = 1'b0; cb_res = {b[3:0], b[7:4]}; end
               SHF_SRL:  begin cb_carry = b[0]; cb_res = {1'b0, b[7:1]}; end
               default:  begin cb_carry = 1'b0; cb_res = b; end
            endcase
            cb_flags = {(cb_res == 8'h00), 1'b0, 1'b0, cb_carry};
         end
         KIND_BIT: begin
            cb_wb    = 1'b0;
            cb_flags = {((b & mask) == 8'h00), 1'b0, 1'b1, f[FLAG_C]};
         end
         KIND_RES: cb_res = b & ~mask;
         KIND_SET: cb_res = b | mask;
         default:  cb_res = b;
      endcase
   end

   always_comb begin
      result.acc_out     = a;
      result.operand_out = 8'h00;
      result.write_back  = 1'b0;
      result.flags_out   = f;
      result.cycles      = CYC_REG;
      result.illegal     = 1'b0;
      if (item.op) begin
         result.operand_out = cb_res;
         result.write_back  = cb_wb;
         result.flags_out   = cb_flags;
         if (item.opcode[2:0] == TGT_A && cb_wb) begin
            result.acc_out = cb_res;
         end
         result.cycles = (item.opcode[2:0] == TGT_HL) ? CYC_CB_MEM : CYC_CB_REG;
      end else if (item.opcode == OPC_CPL) begin
         result.acc_out   = ~a;
         result.flags_out = f | 4'b0110;
      end else if (item.opcode == OPC_SCF) begin
         result.flags_out = {f[FLAG_Z], 3'b001};
      end else if (item.opcode == OPC_CCF) begin
         result.flags_out = {f[FLAG_Z], 2'b00, ~f[FLAG_C]};
      end else if (grp_hit) begin
         result.cycles = (item.opcode[2:0] == TGT_HL) ? CYC_MEM : CYC_REG;
         if (grp == GRP_CP) begin
            result.flags_out = {(a == b), 1'b1, (a[3:0] < b[3:0]), (a < b)};
         end else begin
            result.acc_out   = logic_res;
            result.flags_out = {(logic_res == 8'h00), 1'b0, (grp == GRP_AND), 1'b0};
         end
      end else begin
         result.illegal = 1'b1;
      end
   end

endmodule

// ----- sv/cpu_logic_and_bitop_alu.sv -----
`timescale 1ns / 1ps

// Logic-group and prefixed bit-operation ALU for an 8-bit SM83-style core.
// The request channel carries one instruction per transaction: the opcode,
// the already fetched operand byte, the accumulator and the flags; req_tuser
// tells a main opcode (0) from a byte that followed the prefix (1).
// The response channel returns one transaction per request with the new
// accumulator, the write-back value and its enable, the new flags, the
// cycle count charged and an illegal-opcode indication.
// A request accepted by the handshake is registered in item_ff, evaluated by
// one pass of combinational decode and 8-bit logic, and its response is
// registered in result_ff when the result stage loads, then shown on rsp_.
// One transaction can be accepted every cycle while responses are taken.
// Synchronous reset empties both register stages; no transaction is held.
// When the receiver deasserts rsp_tready, the response stays on the port
// unchanged, the stage behind it fills, and req_tready falls only once
// both stages hold a transaction.
module cpu_logic_and_bitop_alu (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[7:0], operand[15:8], acc_in[23:16], flags_in[27:24], zero[31:28]
   input  logic [31:0] req_tdata,
   // op[0]
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // acc_out[7:0], operand_out[15:8], write_back[16], flags_out[20:17],
   // cycles[25:21], illegal[26], zero[31:27]
   output logic [31:0] rsp_tdata
);
   import clal_pkg::*;

   logic            item_valid_ff;
   logic            item_valid_in;
   clal_item_type   item_ff;
   clal_item_type   item_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   clal_result_type result_ff;
   clal_result_type result_in;
   logic            rsp_load;
   logic            item_load;

   // The result stage takes a new transaction when it is empty or draining.
   assign rsp_load   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !item_valid_ff || rsp_load;
   assign item_load  = req_tvalid && req_tready;

   always_comb begin
      item_in.op       = req_tuser[0];
      item_in.opcode   = req_tdata[7:0];
      item_in.operand  = req_tdata[15:8];
      item_in.acc_in   = req_tdata[23:16];
      item_in.flags_in = req_tdata[27:24];
   end

   assign item_valid_in = item_load || (item_valid_ff && !rsp_load);
   assign rsp_valid_in  = rsp_load ? item_valid_ff : rsp_valid_ff;

   clal_exec u_exec (
      .item   (item_ff),
      .result (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_load) begin
         item_ff <= item_in;
      end
      if (rsp_load && item_valid_ff) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000,
                        result_ff.illegal,
                        result_ff.cycles,
                        result_ff.flags_out,
                        result_ff.write_back,
                        result_ff.operand_out,
                        result_ff.acc_out};

endmodule
